>>> sv/sincos_quarter_table_interp_top_macros.svh
// ---------------------------------------------------------------------------
// sincos_quarter_table_interp_top_macros.svh
// Assertion macros for the quarter-wave sine/cosine block.
// ---------------------------------------------------------------------------
`ifndef SINCOS_QUARTER_TABLE_INTERP_TOP_MACROS_SVH
`define SINCOS_QUARTER_TABLE_INTERP_TOP_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication: when ante holds, cons holds at that edge.
`define SQTI_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("sqti assertion failed");

// Next-cycle implication: when ante holds, cons holds at the next edge.
`define SQTI_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("sqti assertion failed");

`else

`define SQTI_ASSERT_IMP(name, clk, rstn, ante, cons)
`define SQTI_ASSERT_NXT(name, clk, rstn, ante, cons)

`endif

`endif

>>> sv/sqti_pkg.sv
// ---------------------------------------------------------------------------
// sqti_pkg
// Constants and quarter-wave table for the sine/cosine interpolator.
// ---------------------------------------------------------------------------
package sqti_pkg;

  localparam int QUARTER_ENTRIES     = 256;
  localparam int FRACTION_BITS       = 16;
  localparam int ANGLE_FRACTION_BITS = 24;

  localparam int ANGLE_W = 32;
  localparam int OUT_W   = 25;
  localparam int VAL_W   = 24;

  localparam int HALF_ENTRIES = 2 * QUARTER_ENTRIES;
  localparam int Y_W          = $clog2(4 * QUARTER_ENTRIES);  // index modulo a full turn
  localparam int IDX_W        = Y_W - 1;                      // folded index, 0..QUARTER_ENTRIES
  localparam int HALF_SHIFT   = $clog2(HALF_ENTRIES);

  localparam int PROD_W  = 2 * ANGLE_W;
  localparam int PRE_SH  = 13;
  localparam int POS_SH  = 19 + ANGLE_FRACTION_BITS - FRACTION_BITS;
  localparam int POS_W   = PROD_W + HALF_SHIFT;

  localparam logic [ANGLE_W-1:0] INV_PI_Q32 = 32'd1367130551;
  localparam logic [VAL_W-1:0]   FULL_SCALE = 24'd16777215;

  localparam int ROM_LAST = 256;

  localparam logic [VAL_W-1:0] QUARTER_ROM [ROM_LAST+1] = '{
    24'd0, 24'd102943, 24'd205882, 24'd308814, 24'd411733, 24'd514638, 24'd617523,
    24'd720384, 24'd823219, 24'd926022, 24'd1028791, 24'd1131521, 24'd1234208,
    24'd1336849, 24'd1439440, 24'd1541976, 24'd1644455, 24'd1746871, 24'd1849222,
    24'd1951503, 24'd2053710, 24'd2155840, 24'd2257889, 24'd2359854, 24'd2461729,
    24'd2563511, 24'd2665197, 24'd2766783, 24'd2868264, 24'd2969638, 24'd3070900,
    24'd3172046, 24'd3273072, 24'd3373976, 24'd3474752, 24'd3575398, 24'd3675909,
    24'd3776281, 24'd3876512, 24'd3976596, 24'd4076531, 24'd4176312, 24'd4275936,
    24'd4375399, 24'd4474697, 24'd4573827, 24'd4672785, 24'd4771566, 24'd4870168,
    24'd4968587, 24'd5066819, 24'd5164860, 24'd5262706, 24'd5360354, 24'd5457801,
    24'd5555042, 24'd5652074, 24'd5748893, 24'd5845495, 24'd5941878, 24'd6038036,
    24'd6133968, 24'd6229668, 24'd6325134, 24'd6420362, 24'd6515348, 24'd6610089,
    24'd6704581, 24'd6798821, 24'd6892804, 24'd6986528, 24'd7079989, 24'd7173184,
    24'd7266108, 24'd7358759, 24'd7451133, 24'd7543226, 24'd7635035, 24'd7726557,
    24'd7817788, 24'd7908724, 24'd7999363, 24'd8089701, 24'd8179734, 24'd8269459,
    24'd8358873, 24'd8447972, 24'd8536753, 24'd8625212, 24'd8713347, 24'd8801154,
    24'd8888629, 24'd8975770, 24'd9062573, 24'd9149035, 24'd9235152, 24'd9320921,
    24'd9406340, 24'd9491404, 24'd9576111, 24'd9660458, 24'd9744441, 24'd9828057,
    24'd9911303, 24'd9994175, 24'd10076672, 24'd10158789, 24'd10240524,
    24'd10321873, 24'd10402833, 24'd10483402, 24'd10563576, 24'd10643353,
    24'd10722728, 24'd10801700, 24'd10880266, 24'd10958421, 24'd11036164,
    24'd11113492, 24'd11190401, 24'd11266889, 24'd11342953, 24'd11418589,
    24'd11493796, 24'd11568570, 24'd11642908, 24'd11716808, 24'd11790267,
    24'd11863282, 24'd11935851, 24'd12007970, 24'd12079637, 24'd12150849,
    24'd12221604, 24'd12291898, 24'd12361730, 24'd12431096, 24'd12499995,
    24'd12568422, 24'd12636377, 24'd12703856, 24'd12770856, 24'd12837376,
    24'd12903412, 24'd12968963, 24'd13034025, 24'd13098596, 24'd13162675,
    24'd13226258, 24'd13289342, 24'd13351927, 24'd13414009, 24'd13475585,
    24'd13536655, 24'd13597215, 24'd13657263, 24'd13716796, 24'd13775813,
    24'd13834312, 24'd13892290, 24'd13949744, 24'd14006674, 24'd14063076,
    24'd14118949, 24'd14174290, 24'd14229097, 24'd14283369, 24'd14337103,
    24'd14390297, 24'd14442950, 24'd14495058, 24'd14546621, 24'd14597637,
    24'd14648102, 24'd14698016, 24'd14747377, 24'd14796183, 24'd14844431,
    24'd14892121, 24'd14939250, 24'd14985816, 24'd15031818, 24'd15077255,
    24'd15122123, 24'd15166423, 24'd15210151, 24'd15253307, 24'd15295888,
    24'd15337894, 24'd15379322, 24'd15420171, 24'd15460439, 24'd15500126,
    24'd15539228, 24'd15577746, 24'd15615677, 24'd15653021, 24'd15689775,
    24'd15725938, 24'd15761509, 24'd15796487, 24'd15830870, 24'd15864657,
    24'd15897847, 24'd15930438, 24'd15962430, 24'd15993820, 24'd16024609,
    24'd16054794, 24'd16084374, 24'd16113349, 24'd16141718, 24'd16169478,
    24'd16196630, 24'd16223172, 24'd16249103, 24'd16274423, 24'd16299130,
    24'd16323223, 24'd16346701, 24'd16369564, 24'd16391811, 24'd16413441,
    24'd16434453, 24'd16454846, 24'd16474619, 24'd16493772, 24'd16512304,
    24'd16530215, 24'd16547503, 24'd16564168, 24'd16580210, 24'd16595627,
    24'd16610419, 24'd16624587, 24'd16638128, 24'd16651043, 24'd16663330,
    24'd16674991, 24'd16686024, 24'd16696428, 24'd16706204, 24'd16715351,
    24'd16723868, 24'd16731756, 24'd16739014, 24'd16745642, 24'd16751639,
    24'd16757006, 24'd16761742, 24'd16765847, 24'd16769320, 24'd16772162,
    24'd16774373, 24'd16775952, 24'd16776899, 24'd16777215
  };

  // Table read; indices past the stored table return the last entry.
  function automatic logic [VAL_W-1:0] rom_read(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] lim;
    lim = idx;
    if (int'(idx) > ROM_LAST) begin
      lim = IDX_W'(ROM_LAST);
    end
    return QUARTER_ROM[lim];
  endfunction

endpackage

>>> sv/sincos_quarter_table_interp_top.sv
// ---------------------------------------------------------------------------
// sincos_quarter_table_interp_top
// Quarter-wave sine/cosine lookup with linear interpolation, fully pipelined.
// ---------------------------------------------------------------------------
//
//  channel  | ports                               | dir | handshake
//  ---------+-------------------------------------+-----+-------------------------
//  angle    | angle_i[31:0] (Q7.24 radians)       | in  | start & !busy
//  result   | sine_value_o, cosine_value_o [24:0] | out | done_o, one-cycle strobe
//
//  One beat per clock in, one result beat per clock out.
//  An accepted beat reaches done_o through the stages magnitude, multiply,
//  quadrant fold, table read, slope multiply, interpolation add, sign apply.
//  busy is always low: every stage advances every cycle and the receiver
//  cannot hold results off, so nothing ever stalls.
//  Reset clears only the valid bits; payload registers are not reset.
//
`include "sincos_quarter_table_interp_top_macros.svh"

module sincos_quarter_table_interp_top
  import sqti_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [ANGLE_W-1:0] angle_i,
  output logic                      done_o,
  output logic signed [OUT_W-1:0]   sine_value_o,
  output logic signed [OUT_W-1:0]   cosine_value_o
);

  localparam int LATENCY = 7;
  localparam int PROD_S_W = OUT_W + FRACTION_BITS + 1;   // slope * fraction
  localparam int STEP_W   = PROD_S_W - FRACTION_BITS;

  logic accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // valid bits, one per stage
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;

  // stage 1: magnitude and sign of the angle
  logic [ANGLE_W-1:0] mag_d, mag_q;
  logic               neg1_q;

  // stage 2: scale by 1/pi
  logic [PROD_W-1:0]  prod_q;
  logic               neg2_q;

  // stage 3: quadrant fold
  logic [POS_W-1:0]               pos_ext;
  logic [Y_W-1:0]                 y_full;
  logic [FRACTION_BITS-1:0]       frac_raw;
  logic [IDX_W-1:0]               y_half;
  logic                           frac_nz;
  logic                           in_back_half;
  logic                           in_2nd_quarter;
  logic [IDX_W-1:0]               idx_d, idx_q;
  logic [FRACTION_BITS-1:0]       frac_d, frac_q;
  logic                           fnz3_q;
  logic                           sneg3_q, cneg3_q;

  // stage 4: table reads
  logic [IDX_W-1:0]               idx_c;
  logic [IDX_W-1:0]               idx_s_nb, idx_c_nb;
  logic [VAL_W-1:0]               sa_q, sb_q, ca_q, cb_q;
  logic [FRACTION_BITS-1:0]       frac4_q;
  logic                           use_s4_q, use_c4_q;
  logic                           sneg4_q, cneg4_q;

  // stage 5: slope times fraction
  logic signed [OUT_W-1:0]        ds, dc;
  logic signed [FRACTION_BITS:0]  frac_s;
  logic signed [PROD_S_W-1:0]     ps_q, pc_q;
  logic [VAL_W-1:0]               sa5_q, ca5_q;
  logic                           use_s5_q, use_c5_q;
  logic                           sneg5_q, cneg5_q;

  // stage 6: interpolation add (floor shift == truncation, result is non-negative)
  logic signed [STEP_W-1:0]       step_s, step_c;
  logic signed [STEP_W-1:0]       sum_s, sum_c;
  logic [VAL_W-1:0]               vs_d, vc_d, vs_q, vc_q;
  logic                           sneg6_q, cneg6_q;

  // stage 7: sign apply
  logic [OUT_W-1:0]               sout_d, cout_d;
  logic [OUT_W-1:0]               sout_q, cout_q;

  // ---- stage 1 ----
  assign mag_d = angle_i[ANGLE_W-1] ? (ANGLE_W'(0) - ANGLE_W'(angle_i))
                                    : ANGLE_W'(angle_i);

  // ---- stage 3 ----
  // position = ((prod >> 13) * 2Q) >> shift; integer part mod 4Q, plus fraction
  assign pos_ext  = POS_W'(prod_q >> PRE_SH) << HALF_SHIFT;
  assign y_full   = pos_ext[POS_SH + FRACTION_BITS +: Y_W];
  assign frac_raw = pos_ext[POS_SH +: FRACTION_BITS];
  assign frac_nz  = (frac_raw != '0);

  assign in_back_half   = y_full[Y_W-1];
  assign y_half         = y_full[IDX_W-1:0];
  assign in_2nd_quarter = y_half[IDX_W-1];

  always_comb begin
    idx_d  = y_half;
    frac_d = frac_raw;
    if (in_2nd_quarter) begin
      // mirror: 2Q - y, stepping back one when there is a fraction
      idx_d = IDX_W'(HALF_ENTRIES) - y_half - IDX_W'(frac_nz);
      if (frac_nz) begin
        frac_d = FRACTION_BITS'(0) - frac_raw;
      end
    end
  end

  // ---- stage 4 ----
  assign idx_c    = IDX_W'(QUARTER_ENTRIES) - idx_q;
  assign idx_s_nb = (idx_q == IDX_W'(QUARTER_ENTRIES)) ? idx_q : (idx_q + IDX_W'(1));
  assign idx_c_nb = (idx_c == '0) ? idx_c : (idx_c - IDX_W'(1));

  // ---- stage 5 ----
  assign ds     = $signed({1'b0, sb_q}) - $signed({1'b0, sa_q});
  assign dc     = $signed({1'b0, cb_q}) - $signed({1'b0, ca_q});
  assign frac_s = $signed({1'b0, frac4_q});

  // ---- stage 6 ----
  assign step_s = STEP_W'(ps_q >>> FRACTION_BITS);
  assign step_c = STEP_W'(pc_q >>> FRACTION_BITS);
  assign sum_s  = $signed(STEP_W'(sa5_q)) + step_s;
  assign sum_c  = $signed(STEP_W'(ca5_q)) + step_c;
  assign vs_d   = use_s5_q ? VAL_W'(sum_s) : sa5_q;
  assign vc_d   = use_c5_q ? VAL_W'(sum_c) : ca5_q;

  // ---- stage 7 ----
  assign sout_d = sneg6_q ? (OUT_W'(0) - OUT_W'(vs_q)) : OUT_W'(vs_q);
  assign cout_d = cneg6_q ? (OUT_W'(0) - OUT_W'(vc_q)) : OUT_W'(vc_q);

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    neg1_q <= angle_i[ANGLE_W-1];

    prod_q <= PROD_W'(mag_q) * PROD_W'(INV_PI_Q32);
    neg2_q <= neg1_q;

    idx_q   <= idx_d;
    frac_q  <= frac_d;
    fnz3_q  <= frac_nz;
    sneg3_q <= neg2_q ^ in_back_half;
    cneg3_q <= in_back_half ^ in_2nd_quarter;

    sa_q     <= rom_read(idx_q);
    sb_q     <= rom_read(idx_s_nb);
    ca_q     <= rom_read(idx_c);
    cb_q     <= rom_read(idx_c_nb);
    frac4_q  <= frac_q;
    use_s4_q <= fnz3_q;
    use_c4_q <= fnz3_q && (idx_c != '0);
    sneg4_q  <= sneg3_q;
    cneg4_q  <= cneg3_q;

    ps_q     <= PROD_S_W'(ds) * PROD_S_W'(frac_s);
    pc_q     <= PROD_S_W'(dc) * PROD_S_W'(frac_s);
    sa5_q    <= sa_q;
    ca5_q    <= ca_q;
    use_s5_q <= use_s4_q;
    use_c5_q <= use_c4_q;
    sneg5_q  <= sneg4_q;
    cneg5_q  <= cneg4_q;

    vs_q    <= vs_d;
    vc_q    <= vc_d;
    sneg6_q <= sneg5_q;
    cneg6_q <= cneg5_q;

    sout_q <= sout_d;
    cout_q <= cout_d;
  end

  assign done_o         = v7_q;
  assign sine_value_o   = $signed(sout_q);
  assign cosine_value_o = $signed(cout_q);

  // ---- assertions ----
  `SQTI_ASSERT_IMP(a_done_has_beat, clk_i, rst_ni, done_o, $past(accept, LATENCY))
  `SQTI_ASSERT_IMP(a_beat_gives_done, clk_i, rst_ni,
                   $past(accept, LATENCY) && $past(rst_ni, LATENCY), done_o)
  `SQTI_ASSERT_IMP(a_fold_in_range, clk_i, rst_ni, v3_q,
                   idx_q <= IDX_W'(QUARTER_ENTRIES))
  `SQTI_ASSERT_NXT(a_interp_bounded, clk_i, rst_ni, v6_q,
                   vs_q <= FULL_SCALE && vc_q <= FULL_SCALE)

endmodule
